FILE: rtl/core/tmc_pkg.sv
// Shared constants, types and codes of the tile mean colour classifier.
package tmc_pkg;

   // Tile geometry and line store size
   localparam int TILE      = 3;
   localparam int MAX_WIDTH = 2048;
   localparam int TILE_COLS = MAX_WIDTH / TILE;
   localparam int T2        = TILE * TILE;

   // Field widths
   localparam int PIX_W       = 8;
   localparam int THR_W       = 8;
   localparam int CFG_WIDTH_W = 12;
   localparam int COORD_W     = 10;
   localparam int COUNT_W     = 20;
   localparam int ROW_W       = 11;

   // Position counter widths
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int CI_W   = (TILE > 1) ? $clog2(TILE) : 1;
   localparam int TC_RAW = $clog2((MAX_WIDTH - 1) / TILE + 1);
   localparam int TC_W   = (TC_RAW > 0) ? TC_RAW : 1;
   localparam int ADDR_W = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
   localparam int WID_RAW = ($clog2(MAX_WIDTH + 1) > CFG_WIDTH_W) ?
                            $clog2(MAX_WIDTH + 1) : CFG_WIDTH_W;
   localparam int CMP_W  = WID_RAW + 1;

   // Tile sum width: TILE*TILE pixels of at most 255
   localparam int SUM_W = $clog2(T2 * 255 + 1);
   localparam int TH_W  = SUM_W + 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH      = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DARK_GREEN_LIMIT = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_MARGIN       = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLUE_MARGIN      = 4'd3;

   localparam logic [CFG_WIDTH_W-1:0] IMAGE_WIDTH_RESET      = 12'd640;
   localparam logic [THR_W-1:0]       DARK_GREEN_LIMIT_RESET = 8'd65;
   localparam logic [THR_W-1:0]       RED_MARGIN_RESET       = 8'd15;
   localparam logic [THR_W-1:0]       BLUE_MARGIN_RESET      = 8'd30;

   // Class codes
   typedef enum logic [2:0] {
      CLASS_SHADOW = 3'd0,
      CLASS_SUN    = 3'd1,
      CLASS_LEAF   = 3'd2,
      CLASS_WHITE  = 3'd3,
      CLASS_RED    = 3'd4
   } tmc_class_type;

   typedef struct packed {
      logic [CFG_WIDTH_W-1:0] image_width;
      logic [THR_W-1:0]       dark_green_limit;
      logic [THR_W-1:0]       red_margin;
      logic [THR_W-1:0]       blue_margin;
   } tmc_cfg_type;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      logic             frame_start;
   } tmc_req_type;

   typedef struct packed {
      logic [2:0]         tile_class;
      logic [COORD_W-1:0] tile_row;
      logic [COORD_W-1:0] tile_column;
      logic [COUNT_W-1:0] shadow_count;
      logic [COUNT_W-1:0] sun_count;
   } tmc_rsp_type;

   // Classified pixel as handed from front to back
   typedef struct packed {
      tmc_req_type        pixel;
      logic               in_range;
      logic               start;
      logic               finish;
      logic [ADDR_W-1:0]  addr;
      logic [COORD_W-1:0] tile_row;
      logic [COORD_W-1:0] tile_column;
   } tmc_cmd_type;

endpackage

FILE: rtl/core/tile_mean_color_classifier_unit.sv
// Top level of the tile mean colour classifier: registers, front, queue and back.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     req_data  (tmc_req_type)
//   rsp      out        rsp_valid / rsp_ready     rsp_data  (tmc_rsp_type)
//   csr      in         csr_valid / csr_ready     csr_index, csr_data
//
// One pixel is taken per cycle while req_ready is high; the line store is read
// as an item leaves the queue and written as it leaves the summing stage, with
// the just written sums forwarded. A tile result is registered as its last
// pixel leaves the classify stage. Reset clears positions, counts and stage
// valids; the line store has no reset. A stalled result holds the back stages;
// the two-entry queue then takes up to two more items before req_ready drops.
module tile_mean_color_classifier_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tmc_pkg::tmc_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tmc_pkg::tmc_rsp_type                rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tmc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tmc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import tmc_pkg::*;

   tmc_cfg_type cfg_ff;
   tmc_cmd_type front_cmd, back_cmd;
   logic        front_valid, front_ready, back_valid, back_ready;

   assign csr_ready = 1'b1;

   // Write configuration registers; unknown indexes drop the item
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width      <= IMAGE_WIDTH_RESET;
         cfg_ff.dark_green_limit <= DARK_GREEN_LIMIT_RESET;
         cfg_ff.red_margin       <= RED_MARGIN_RESET;
         cfg_ff.blue_margin      <= BLUE_MARGIN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               cfg_ff.image_width <= csr_data[CFG_WIDTH_W-1:0];
            end
            CSR_DARK_GREEN_LIMIT: begin
               cfg_ff.dark_green_limit <= csr_data[THR_W-1:0];
            end
            CSR_RED_MARGIN: begin
               cfg_ff.red_margin <= csr_data[THR_W-1:0];
            end
            CSR_BLUE_MARGIN: begin
               cfg_ff.blue_margin <= csr_data[THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   tmc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd_data  (front_cmd)
   );

   tmc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_cmd)
   );

   tmc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .cmd_data  (back_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/core/tmc_front.sv
// Front part: tracks the raster position and tags each pixel with its tile role.
module tmc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  tmc_pkg::tmc_cfg_type cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tmc_pkg::tmc_req_type req_data,
   output logic                 cmd_valid,
   input  logic                 cmd_ready,
   output tmc_pkg::tmc_cmd_type cmd_data
);
   import tmc_pkg::*;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [CI_W-1:0]  ri;
      logic [ROW_W-1:0] trow;
   } row_pos_type;

   // Step to the next row, wrapping at the top of the row counter
   function automatic row_pos_type next_row(row_pos_type p);
      row_pos_type n;
      n = p;
      if (p.row == {ROW_W{1'b1}}) begin
         n = '0;
      end else begin
         n.row = p.row + 1'b1;
         if (p.ri == CI_W'(TILE - 1)) begin
            n.ri   = '0;
            n.trow = p.trow + 1'b1;
         end else begin
            n.ri = p.ri + 1'b1;
         end
      end
      return n;
   endfunction

   logic [COL_W-1:0] col_ff, col_in, col_p;
   logic [CI_W-1:0]  ci_ff, ci_in, ci_p;
   logic [TC_W-1:0]  tc_ff, tc_in, tc_p;
   row_pos_type      rp_ff, rp_in, rp_p;

   logic [CMP_W-1:0] width_raw, width_eff, tile_end, col_sum;
   logic             in_range, accept;

   // Clamp the configured width to the supported range
   always_comb begin
      width_raw = CMP_W'(cfg.image_width);
      if (width_raw == '0) begin
         width_eff = CMP_W'(1);
      end else if (width_raw > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end else begin
         width_eff = width_raw;
      end
   end

   // Position of this pixel: frame start clears, a shrunk width wraps first
   always_comb begin
      col_p = col_ff;
      ci_p  = ci_ff;
      tc_p  = tc_ff;
      rp_p  = rp_ff;
      if (req_data.frame_start) begin
         col_p = '0;
         ci_p  = '0;
         tc_p  = '0;
         rp_p  = '0;
      end else if (CMP_W'(col_ff) >= width_eff) begin
         col_p = '0;
         ci_p  = '0;
         tc_p  = '0;
         rp_p  = next_row(rp_ff);
      end
   end

   // Tag the pixel: a tile counts only if its last column lies inside the row and its column fits the line store
   always_comb begin
      tile_end = CMP_W'(col_p) + CMP_W'(TILE - 1) - CMP_W'(ci_p);
      in_range = (tile_end < width_eff) && ((TC_W + 1)'(tc_p) < (TC_W + 1)'(TILE_COLS));

      cmd_data.pixel       = req_data;
      cmd_data.in_range    = in_range;
      cmd_data.start       = (rp_p.ri == '0) && (ci_p == '0);
      cmd_data.finish      = in_range && (rp_p.ri == CI_W'(TILE - 1)) &&
                             (ci_p == CI_W'(TILE - 1));
      cmd_data.addr        = in_range ? tc_p[ADDR_W-1:0] : '0;
      cmd_data.tile_row    = COORD_W'(rp_p.trow);
      cmd_data.tile_column = COORD_W'(tc_p);
   end

   // Advance one column, wrapping to the next row at the end of the row
   always_comb begin
      col_sum = CMP_W'(col_p) + CMP_W'(1);
      if (col_sum >= width_eff) begin
         col_in = '0;
         ci_in  = '0;
         tc_in  = '0;
         rp_in  = next_row(rp_p);
      end else begin
         col_in = col_sum[COL_W-1:0];
         rp_in  = rp_p;
         if (ci_p == CI_W'(TILE - 1)) begin
            ci_in = '0;
            tc_in = tc_p + 1'b1;
         end else begin
            ci_in = ci_p + 1'b1;
            tc_in = tc_p;
         end
      end
   end

   assign cmd_valid = req_valid;
   assign req_ready = cmd_ready;
   assign accept    = req_valid && cmd_ready;

   // Hold the position until an item is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         ci_ff  <= '0;
         tc_ff  <= '0;
         rp_ff  <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         ci_ff  <= ci_in;
         tc_ff  <= tc_in;
         rp_ff  <= rp_in;
      end
   end

endmodule

FILE: rtl/core/tmc_queue.sv
// Short queue that decouples the front part from the back part.
module tmc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  tmc_pkg::tmc_cmd_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output tmc_pkg::tmc_cmd_type pop_data
);
   import tmc_pkg::*;

   tmc_cmd_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/tmc_back.sv
// Back part: line store update, tile classification and tile counters.
module tmc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  tmc_pkg::tmc_cfg_type cfg,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  tmc_pkg::tmc_cmd_type cmd_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tmc_pkg::tmc_rsp_type rsp_data
);
   import tmc_pkg::*;

   typedef struct packed {
      logic [SUM_W-1:0] b;
      logic [SUM_W-1:0] g;
      logic [SUM_W-1:0] r;
   } sums_type;

   // Compare tile sums against thresholds scaled by the tile area
   function automatic tmc_class_type classify(sums_type s, tmc_cfg_type c);
      logic [TH_W-1:0] g, dark_lim, red_lim, blue_lim;
      tmc_class_type   cls;
      g        = TH_W'(s.g);
      dark_lim = TH_W'(c.dark_green_limit) * TH_W'(T2);
      red_lim  = TH_W'(s.r) + TH_W'(c.red_margin) * TH_W'(T2);
      blue_lim = TH_W'(s.b) + TH_W'(c.blue_margin) * TH_W'(T2);
      if (s.g > s.r && s.g > s.b) begin
         if (g < dark_lim) begin
            cls = CLASS_SHADOW;
         end else if (g > red_lim && g > blue_lim) begin
            cls = CLASS_SUN;
         end else begin
            cls = CLASS_LEAF;
         end
      end else if (s.r > s.g && s.g > s.b) begin
         cls = CLASS_WHITE;
      end else begin
         cls = CLASS_RED;
      end
      return cls;
   endfunction

   sums_type line_mem [TILE_COLS];

   logic        r_valid_ff, s_valid_ff, o_valid_ff;
   tmc_cmd_type r_cmd_ff, s_cmd_ff;
   sums_type    r_mem_ff, r_hit_data_ff, s_sums_ff;
   logic        r_hit_ff;
   tmc_rsp_type o_data_ff;
   logic [COUNT_W-1:0] shadow_ff, shadow_in, sun_ff, sun_in;
   logic [COUNT_W-1:0] shadow_base, sun_base;

   logic          pop, r_adv, s_adv, r_ready, s_ready, o_ready, wr_en;
   sums_type      base, r_sum;
   tmc_class_type cls;

   // Stall chain from the result side back to the queue
   assign o_ready   = !o_valid_ff || rsp_ready;
   assign s_adv     = s_valid_ff && (!s_cmd_ff.finish || o_ready);
   assign s_ready   = !s_valid_ff || s_adv;
   assign r_adv     = r_valid_ff && s_ready;
   assign r_ready   = !r_valid_ff || r_adv;
   assign cmd_ready = r_ready;
   assign pop       = cmd_valid && r_ready;
   assign wr_en     = r_adv && r_cmd_ff.in_range;

   // Start a tile row from zero, else add onto the stored or just written sums
   always_comb begin
      if (r_cmd_ff.start) begin
         base = '0;
      end else if (r_hit_ff) begin
         base = r_hit_data_ff;
      end else begin
         base = r_mem_ff;
      end
      r_sum.b = base.b + SUM_W'(r_cmd_ff.pixel.blue);
      r_sum.g = base.g + SUM_W'(r_cmd_ff.pixel.green);
      r_sum.r = base.r + SUM_W'(r_cmd_ff.pixel.red);
   end

   // Line store: read on pop, write an in-range item when the summing stage moves on
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[r_cmd_ff.addr] <= r_sum;
      end
      if (pop) begin
         r_mem_ff <= line_mem[cmd_data.addr];
      end
   end

   // Catch a write to the same entry at the edge of the read
   always_ff @(posedge clock) begin
      if (pop) begin
         r_cmd_ff      <= cmd_data;
         r_hit_ff      <= wr_en && (r_cmd_ff.addr == cmd_data.addr);
         r_hit_data_ff <= r_sum;
      end
      if (r_adv) begin
         s_cmd_ff  <= r_cmd_ff;
         s_sums_ff <= r_sum;
      end
   end

   // Classify and update the saturating counts
   always_comb begin
      cls         = classify(s_sums_ff, cfg);
      shadow_base = s_cmd_ff.pixel.frame_start ? '0 : shadow_ff;
      sun_base    = s_cmd_ff.pixel.frame_start ? '0 : sun_ff;
      shadow_in   = shadow_base;
      sun_in      = sun_base;
      if (s_cmd_ff.finish && cls == CLASS_SHADOW && shadow_base != COUNT_MAX) begin
         shadow_in = shadow_base + 1'b1;
      end
      if (s_cmd_ff.finish && cls == CLASS_SUN && sun_base != COUNT_MAX) begin
         sun_in = sun_base + 1'b1;
      end
   end

   // Stage valids and counts
   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
         shadow_ff  <= '0;
         sun_ff     <= '0;
      end else begin
         if (r_ready) begin
            r_valid_ff <= cmd_valid;
         end
         if (s_ready) begin
            s_valid_ff <= r_valid_ff;
         end
         if (s_adv && s_cmd_ff.finish) begin
            o_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            o_valid_ff <= 1'b0;
         end
         if (s_adv) begin
            shadow_ff <= shadow_in;
            sun_ff    <= sun_in;
         end
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (s_adv && s_cmd_ff.finish) begin
         o_data_ff.tile_class   <= cls;
         o_data_ff.tile_row     <= s_cmd_ff.tile_row;
         o_data_ff.tile_column  <= s_cmd_ff.tile_column;
         o_data_ff.shadow_count <= shadow_in;
         o_data_ff.sun_count    <= sun_in;
      end
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_data  = o_data_ff;

endmodule
